// ===== design/mq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mq_pkg;

   // Default geometry of the queue.
   localparam int Depth     = 1024;
   localparam int DataWidth = 32;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_PEEK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== design/mq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mq_req_if #(
   parameter int DATA_WIDTH = mq_pkg::DataWidth
);
   logic                  valid;
   logic                  ready;
   mq_pkg::op_type        opcode;
   logic [DATA_WIDTH-1:0] new_value;

   modport source (output valid, output opcode, output new_value, input ready);
   modport sink   (input valid, input opcode, input new_value, output ready);
endinterface

`default_nettype wire

// ===== design/mq_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mq_rsp_if #(
   parameter int DATA_WIDTH = mq_pkg::DataWidth,
   parameter int CNT_W      = $clog2(mq_pkg::Depth + 1)
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] front_value;
   logic [DATA_WIDTH-1:0] extreme_value;
   logic [CNT_W-1:0]      occupancy;
   logic                  is_empty;
   mq_pkg::status_type    status;

   modport source (output valid, output front_value, output extreme_value,
                   output occupancy, output is_empty, output status, input ready);
   modport sink   (input valid, input front_value, input extreme_value,
                   input occupancy, input is_empty, input status, output ready);
endinterface

`default_nettype wire

// ===== design/mq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module mq_ram #(
   parameter int DEPTH = mq_pkg::Depth,
   parameter int WIDTH = 2 * mq_pkg::DataWidth
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

// ===== design/min_queue_two_stacks.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// req       in   req.valid/req.ready  opcode, new_value
// rsp       out  rsp.valid/rsp.ready  front_value, extreme_value, occupancy, is_empty, status
// csr       in   csr_valid/csr_ready  csr_data (max_mode)
//
// Push, clear, peek and a pop that empties the output stack go from acceptance straight to
// S_DONE, where the response is loaded; a pop that exposes a lower output entry passes
// through S_LOAD first, for the RAM read. A pop that finds the output stack empty first
// moves all its held values but the bottom one, one per cycle in S_MOVE, and then loads
// the response in S_DONE. The next transaction is taken in the cycle after each load.
// Reset clears counts, mode and handshake state only; a response stalled on rsp.ready
// holds the next one in S_DONE, and the counts guard every RAM read.

module min_queue_two_stacks #(
   parameter int DEPTH      = mq_pkg::Depth,
   parameter int DATA_WIDTH = mq_pkg::DataWidth
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mq_req_if.sink      req,
   mq_rsp_if.source    rsp,
   input  wire logic   csr_valid,
   output logic        csr_ready,
   input  wire logic   csr_data
);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ENT_W  = 2 * DATA_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MOVE = 4'b0010,
      S_LOAD = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   // True when a should replace b as the running extreme.
   function automatic logic beats(input logic max_mode, input logic [DATA_WIDTH-1:0] a,
                                  input logic [DATA_WIDTH-1:0] b);
      beats = max_mode ? (a > b) : (a < b);
   endfunction

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   in_cnt_ff, in_cnt_in;
   logic [CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   // Cached copies of the stack tops and of the bottom of the input stack, so that
   // every response comes from registers without a RAM read.
   logic [DATA_WIDTH-1:0] in_top_ext_ff, in_top_ext_in;
   logic [DATA_WIDTH-1:0] in_bot_val_ff, in_bot_val_in;
   logic [DATA_WIDTH-1:0] out_top_val_ff, out_top_val_in;
   logic [DATA_WIDTH-1:0] out_top_ext_ff, out_top_ext_in;
   logic                  mode_ff, mode_in;
   mq_pkg::status_type    status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_front_ff, rsp_front_in;
   logic [DATA_WIDTH-1:0] rsp_ext_ff, rsp_ext_in;
   logic [CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   mq_pkg::status_type    rsp_status_ff, rsp_status_in;

   logic                  in_we, out_we;
   logic [ADDR_W-1:0]     in_wr_addr, out_wr_addr, in_rd_addr, out_rd_addr;
   logic [ENT_W-1:0]      in_wr_data, out_wr_data, in_rd_data, out_rd_data;

   logic [CNT_W-1:0]      total;
   logic [CNT_W-1:0]      in_cnt_m1, in_cnt_m2, out_cnt_m2;
   logic [DATA_WIDTH-1:0] push_ext, move_val, move_ext;
   logic [DATA_WIDTH-1:0] front_now, ext_now;

   mq_ram #(.DEPTH(DEPTH), .WIDTH(ENT_W)) u_in_stack (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (in_wr_addr),
      .wr_data (in_wr_data),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   mq_ram #(.DEPTH(DEPTH), .WIDTH(ENT_W)) u_out_stack (
      .clock   (clock),
      .wr_en   (out_we),
      .wr_addr (out_wr_addr),
      .wr_data (out_wr_data),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   assign total      = in_cnt_ff + out_cnt_ff;
   assign in_cnt_m1  = in_cnt_ff - CNT_W'(1);
   assign in_cnt_m2  = in_cnt_ff - CNT_W'(2);
   assign out_cnt_m2 = out_cnt_ff - CNT_W'(2);

   // Running extreme of a new entry on the input stack.
   assign push_ext = (in_cnt_ff == '0) ? req.new_value :
                     (beats(mode_ff, req.new_value, in_top_ext_ff) ? req.new_value
                                                                   : in_top_ext_ff);

   // During a transfer the read data is the current input stack top; it is pushed
   // onto the output stack with the output top's extreme held in a register.
   assign move_val = in_rd_data[ENT_W-1:DATA_WIDTH];
   assign move_ext = (out_cnt_ff == '0) ? move_val :
                     (beats(mode_ff, move_val, out_top_ext_ff) ? move_val : out_top_ext_ff);

   // Response fields from the cached tops. The final choice between the two stacks
   // uses the mode now in force.
   always_comb begin
      front_now = '0;
      ext_now   = '0;
      if (out_cnt_ff != '0) begin
         front_now = out_top_val_ff;
      end else if (in_cnt_ff != '0) begin
         front_now = in_bot_val_ff;
      end
      if (out_cnt_ff == '0 && in_cnt_ff != '0) begin
         ext_now = in_top_ext_ff;
      end else if (in_cnt_ff == '0 && out_cnt_ff != '0) begin
         ext_now = out_top_ext_ff;
      end else if (in_cnt_ff != '0 && out_cnt_ff != '0) begin
         ext_now = beats(mode_ff, out_top_ext_ff, in_top_ext_ff) ? out_top_ext_ff
                                                                : in_top_ext_ff;
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      in_cnt_in      = in_cnt_ff;
      out_cnt_in     = out_cnt_ff;
      in_top_ext_in  = in_top_ext_ff;
      in_bot_val_in  = in_bot_val_ff;
      out_top_val_in = out_top_val_ff;
      out_top_ext_in = out_top_ext_ff;
      status_in      = status_ff;
      mode_in        = csr_valid ? csr_data : mode_ff;

      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_front_in  = rsp_front_ff;
      rsp_ext_in    = rsp_ext_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;

      in_we       = 1'b0;
      in_wr_addr  = in_cnt_ff[ADDR_W-1:0];
      in_wr_data  = {req.new_value, push_ext};
      in_rd_addr  = in_cnt_m1[ADDR_W-1:0];
      out_we      = 1'b0;
      out_wr_addr = out_cnt_ff[ADDR_W-1:0];
      out_wr_data = {move_val, move_ext};
      out_rd_addr = out_cnt_m2[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               status_in = mq_pkg::ST_OK;
               state_in  = S_DONE;
               case (req.opcode)
                  mq_pkg::OP_PUSH: begin
                     if (total == CNT_W'(DEPTH)) begin
                        status_in = mq_pkg::ST_FULL;
                     end else begin
                        in_we         = 1'b1;
                        in_top_ext_in = push_ext;
                        in_cnt_in     = in_cnt_ff + CNT_W'(1);
                        if (in_cnt_ff == '0) begin
                           in_bot_val_in = req.new_value;
                        end
                     end
                  end
                  mq_pkg::OP_POP: begin
                     if (total == '0) begin
                        status_in = mq_pkg::ST_EMPTY;
                     end else if (out_cnt_ff != '0) begin
                        // The entry below the popped one becomes the new top.
                        out_cnt_in = out_cnt_ff - CNT_W'(1);
                        if (out_cnt_ff != CNT_W'(1)) begin
                           state_in = S_LOAD;
                        end
                     end else begin
                        // Output stack empty: start the transfer, the read of the
                        // input stack top is issued in this cycle.
                        state_in = S_MOVE;
                     end
                  end
                  mq_pkg::OP_CLEAR: begin
                     in_cnt_in  = '0;
                     out_cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOVE: begin
            if (in_cnt_ff == CNT_W'(1)) begin
               // The bottom entry is the one being popped, so it is never written
               // to the output stack and the cached output top stays as it is.
               in_cnt_in = '0;
               state_in  = S_DONE;
            end else begin
               out_we         = 1'b1;
               out_top_val_in = move_val;
               out_top_ext_in = move_ext;
               out_cnt_in     = out_cnt_ff + CNT_W'(1);
               in_cnt_in      = in_cnt_m1;
               in_rd_addr     = in_cnt_m2[ADDR_W-1:0];
            end
         end
         S_LOAD: begin
            out_top_val_in = out_rd_data[ENT_W-1:DATA_WIDTH];
            out_top_ext_in = out_rd_data[DATA_WIDTH-1:0];
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_front_in  = front_now;
               rsp_ext_in    = ext_now;
               rsp_occ_in    = total;
               rsp_empty_in  = (total == '0);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_top_ext_ff  <= in_top_ext_in;
      in_bot_val_ff  <= in_bot_val_in;
      out_top_val_ff <= out_top_val_in;
      out_top_ext_ff <= out_top_ext_in;
      status_ff      <= status_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_ext_ff     <= rsp_ext_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.front_value   = rsp_front_ff;
   assign rsp.extreme_value = rsp_ext_ff;
   assign rsp.occupancy     = rsp_occ_ff;
   assign rsp.is_empty      = rsp_empty_ff;
   assign rsp.status        = rsp_status_ff;

endmodule

`default_nettype wire

// ===== tb/sv/min_queue_two_stacks_checker.sv =====
`timescale 1ns / 1ps

module min_queue_two_stacks_checker #(
   parameter int DEPTH      = mq_pkg::Depth,
   parameter int DATA_WIDTH = mq_pkg::DataWidth,
   parameter int CNT_W      = $clog2(mq_pkg::Depth + 1)
) (
   input  logic clock,
   input  logic reset,
   mq_req_if    req,
   mq_rsp_if    rsp,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic csr_data,
   output int   failures,
   output int   pending,
   output int   checked
);
   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type           front_value;
      word_type           extreme_value;
      logic [CNT_W-1:0]   occupancy;
      logic               is_empty;
      mq_pkg::status_type status;
   } queue_view_type;

   // Each stack entry keeps its value and the running extreme of itself and
   // every entry below it, in the mode that held when it was written.
   word_type       push_val [DEPTH];
   word_type       push_ext [DEPTH];
   word_type       pop_val  [DEPTH];
   word_type       pop_ext  [DEPTH];
   int unsigned    push_depth;
   int unsigned    pop_depth;
   logic           track_max;
   queue_view_type expected_views [$];

   function automatic logic wins(word_type a, word_type b);
      return track_max ? (a > b) : (a < b);
   endfunction

   function automatic word_type running_extreme(word_type v, word_type below,
                                                int unsigned depth);
      if (depth == 0)
         return v;
      return wins(v, below) ? v : below;
   endfunction

   // Applies one transaction to the shadow queue and returns what the block
   // should report afterwards.
   function automatic queue_view_type apply_op(mq_pkg::op_type op, word_type v);
      queue_view_type view;
      word_type       moved;
      word_type       below;
      int unsigned    total;
      view        = '0;
      view.status = mq_pkg::ST_OK;
      case (op)
         mq_pkg::OP_PUSH: begin
            if (push_depth + pop_depth >= DEPTH) begin
               view.status = mq_pkg::ST_FULL;
            end else begin
               below = (push_depth > 0) ? push_ext[push_depth - 1] : '0;
               push_val[push_depth] = v;
               push_ext[push_depth] = running_extreme(v, below, push_depth);
               push_depth++;
            end
         end
         mq_pkg::OP_POP: begin
            if (push_depth + pop_depth == 0) begin
               view.status = mq_pkg::ST_EMPTY;
            end else begin
               if (pop_depth == 0) begin
                  while (push_depth > 0) begin
                     moved = push_val[push_depth - 1];
                     push_depth--;
                     below = (pop_depth > 0) ? pop_ext[pop_depth - 1] : '0;
                     pop_val[pop_depth] = moved;
                     pop_ext[pop_depth] = running_extreme(moved, below, pop_depth);
                     pop_depth++;
                  end
               end
               pop_depth--;
            end
         end
         mq_pkg::OP_CLEAR: begin
            push_depth = 0;
            pop_depth  = 0;
         end
         default: begin
         end
      endcase

      total          = push_depth + pop_depth;
      view.occupancy = CNT_W'(total);
      view.is_empty  = (total == 0);
      if (pop_depth > 0)
         view.front_value = pop_val[pop_depth - 1];
      else if (push_depth > 0)
         view.front_value = push_val[0];

      if (pop_depth == 0 && push_depth > 0)
         view.extreme_value = push_ext[push_depth - 1];
      else if (push_depth == 0 && pop_depth > 0)
         view.extreme_value = pop_ext[pop_depth - 1];
      else if (push_depth > 0 && pop_depth > 0)
         view.extreme_value = wins(pop_ext[pop_depth - 1], push_ext[push_depth - 1]) ?
                              pop_ext[pop_depth - 1] : push_ext[push_depth - 1];
      return view;
   endfunction

   always @(posedge clock) begin
      queue_view_type want;
      if (reset) begin
         push_depth = 0;
         pop_depth  = 0;
         track_max  = 1'b0;
         expected_views.delete();
         failures   = 0;
         checked    = 0;
      end else begin
         if (csr_valid && csr_ready)
            track_max = csr_data;
         if (req.valid && req.ready)
            expected_views.push_back(apply_op(req.opcode, req.new_value));
         if (rsp.valid && rsp.ready) begin
            if (expected_views.size() == 0) begin
               $error("response transaction arrived with none outstanding");
               failures++;
            end else begin
               want = expected_views.pop_front();
               checked++;
               if (rsp.front_value !== want.front_value) begin
                  $error("front_value: expected %0h, got %0h",
                         want.front_value, rsp.front_value);
                  failures++;
               end
               if (rsp.extreme_value !== want.extreme_value) begin
                  $error("extreme_value: expected %0h, got %0h",
                         want.extreme_value, rsp.extreme_value);
                  failures++;
               end
               if (rsp.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
                  failures++;
               end
               if (rsp.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0b, got %0b", want.is_empty, rsp.is_empty);
                  failures++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  failures++;
               end
            end
         end
      end
      pending = expected_views.size();
   end

endmodule

// ===== tb/sv/min_queue_two_stacks_tb.sv =====
`timescale 1ns / 1ps

module min_queue_two_stacks_tb;

   localparam int DATA_WIDTH    = mq_pkg::DataWidth;
   localparam int DEPTH         = mq_pkg::Depth;
   // Random transactions spread over four phases of mode and idling.
   localparam int RandomItems   = 64;
   // The slowest legal quiet stretch is a pop that moves a full input stack
   // followed by a long response stall, so this leaves a wide margin.
   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic csr_data;

   // Idling switches for the two sides; each phase picks its own mix.
   logic req_idle_on;
   logic rsp_idle_on;

   int failures;
   int pending;
   int checked;
   int op_count [4];
   int stall_left;
   int quiet_cycles;

   mq_req_if req_bus ();
   mq_rsp_if rsp_bus ();

   min_queue_two_stacks dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // The checker shadows the queue, predicts every response and counts the
   // mismatches; this module only makes stimulus and gives the verdict.
   min_queue_two_stacks_checker result_check (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending),
      .checked   (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap(logic enabled);
      int roll;
      if (!enabled)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Values lean toward the ends of the range and toward a small set, so
   // that ties and both extremes show up often in the running extreme.
   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom_range(0, 15);
         5:       return '1 - $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic mq_pkg::op_type pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 48)
         return mq_pkg::OP_PUSH;
      if (roll < 85)
         return mq_pkg::OP_POP;
      if (roll < 97)
         return mq_pkg::OP_PEEK;
      return mq_pkg::OP_CLEAR;
   endfunction

   // The response side stalls on its own schedule. Ready gets exactly one
   // update per falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= pick_gap(rsp_idle_on);
      end
   end

   // Watchdog: any accepted transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
         $display("min_queue_two_stacks regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request at a falling edge and holds it until the block
   // takes it. Valid stays high when no gap follows, so back-to-back
   // transactions never see valid dropped and raised in the same step.
   task automatic send_item(mq_pkg::op_type op, logic [DATA_WIDTH-1:0] value);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.new_value <= value;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      op_count[int'(op)]++;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops sending and waits until every predicted response has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // The mode register is only written while nothing is in flight.
   task automatic write_mode(logic mode);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic. Most of it is short mixed runs; some of it is a burst
   // of pushes drained by as many pops and a few more, which forces stack
   // transfers and pops on an empty queue; the rest is lone peeks and clears.
   // A burst is trimmed to what is left of the quota.
   task automatic random_traffic(int quota);
      int issued;
      int burst;
      int kind;
      issued = 0;
      while (issued < quota) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            repeat ($urandom_range(1, 8)) begin
               send_item(pick_op(), pick_value());
               issued++;
            end
         end else if (kind < 9) begin
            burst = $urandom_range(4, 60);
            if (2 * burst + 3 > quota - issued)
               burst = (quota - issued) / 2;
            repeat (burst) begin
               send_item(mq_pkg::OP_PUSH, pick_value());
               issued++;
            end
            repeat (burst + $urandom_range(0, 3)) begin
               send_item(mq_pkg::OP_POP, $urandom);
               issued++;
            end
         end else begin
            send_item(($urandom_range(0, 1) != 0) ? mq_pkg::OP_PEEK : mq_pkg::OP_CLEAR,
                      $urandom);
            issued++;
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_data          = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = mq_pkg::OP_PEEK;
      req_bus.new_value = '0;
      rsp_bus.ready     = 1'b0;
      req_idle_on       = 1'b1;
      rsp_idle_on       = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part in minimum mode: the empty-queue cases first, then the
      // value extremes, a pop that moves the input stack, and a pop taken
      // while both stacks hold values.
      write_mode(1'b0);
      send_item(mq_pkg::OP_POP, '1);
      send_item(mq_pkg::OP_PEEK, '0);
      send_item(mq_pkg::OP_CLEAR, '1);
      send_item(mq_pkg::OP_PUSH, '1);
      send_item(mq_pkg::OP_PUSH, '0);
      send_item(mq_pkg::OP_PUSH, 32'h8000_0000);
      send_item(mq_pkg::OP_PUSH, 32'h0000_0001);
      send_item(mq_pkg::OP_PEEK, 32'h5555_5555);
      send_item(mq_pkg::OP_POP, 32'hAAAA_AAAA);
      send_item(mq_pkg::OP_PUSH, 32'h0000_0007);
      repeat (4) send_item(mq_pkg::OP_POP, '0);
      send_item(mq_pkg::OP_POP, '0);

      // Maximum mode, then a switch back to minimum while values are still
      // held, so that the reported extreme mixes both modes.
      write_mode(1'b1);
      send_item(mq_pkg::OP_PUSH, 32'h0000_0005);
      send_item(mq_pkg::OP_PUSH, '1);
      send_item(mq_pkg::OP_PUSH, '0);
      send_item(mq_pkg::OP_POP, '0);
      send_item(mq_pkg::OP_PUSH, 32'h0000_0009);
      send_item(mq_pkg::OP_PEEK, '0);
      write_mode(1'b0);
      send_item(mq_pkg::OP_PEEK, '0);
      send_item(mq_pkg::OP_PUSH, 32'h0000_0002);
      send_item(mq_pkg::OP_POP, '0);
      send_item(mq_pkg::OP_CLEAR, '0);

      // Fill the queue to capacity, push into the full queue, then pop once
      // so the whole input stack moves across, and fill the freed slot.
      write_mode(1'b1);
      repeat (DEPTH) send_item(mq_pkg::OP_PUSH, pick_value());
      repeat (3) send_item(mq_pkg::OP_PUSH, pick_value());
      send_item(mq_pkg::OP_PEEK, $urandom);
      send_item(mq_pkg::OP_POP, $urandom);
      send_item(mq_pkg::OP_PUSH, pick_value());
      send_item(mq_pkg::OP_PUSH, pick_value());
      repeat (5) send_item(mq_pkg::OP_POP, $urandom);
      send_item(mq_pkg::OP_CLEAR, $urandom);

      // Random phases. The mode changes between phases without clearing,
      // and the idling mix differs in each, including one with none at all.
      write_mode(1'b0);
      random_traffic(RandomItems / 4);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_mode(1'b1);
      random_traffic(RandomItems / 4);
      req_idle_on = 1'b1;
      write_mode(1'b0);
      random_traffic(RandomItems / 4);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      write_mode(1'b1);
      random_traffic(RandomItems / 4);

      wait_idle();
      repeat (8) @(negedge clock);

      $display("Sent %0d pushes, %0d pops, %0d clears and %0d peeks; %0d responses checked.",
               op_count[int'(mq_pkg::OP_PUSH)], op_count[int'(mq_pkg::OP_POP)],
               op_count[int'(mq_pkg::OP_CLEAR)], op_count[int'(mq_pkg::OP_PEEK)], checked);
      $display("Both modes ran, with a full queue, empty pops and mode changes mid-content.");
      if (failures == 0)
         $display("min_queue_two_stacks regression: pass");
      else
         $display("min_queue_two_stacks regression: fail");
      $finish;
   end

endmodule
